[rtl/core/pfe_pkg.sv]
// Shared types, character codes and decode helpers for the postfix evaluator.
package pfe_pkg;

    localparam int DATA_W        = 32;
    localparam int SYM_W         = 8;
    localparam int STATUS_W      = 2;
    localparam int STACK_DEPTH_D = 128;

    localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_BAD
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic    finish;
        logic    push_digit;
        logic    latch_op;
        logic    set_err;
        t_status err_code;
        logic    pop_two;
        logic    commit_alu;
        logic    div_start;
        logic    div_commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sym_nul;
        logic sym_digit;
        logic err_latched;
        logic count_lt2;
        logic rhs_zero;
        logic out_busy;
        logic div_done;
        t_op  op;
    } t_stat;

    function automatic t_op decode_op(input logic [SYM_W-1:0] sym);
        t_op op;
        case (sym)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_BAD;
        endcase
        return op;
    endfunction

endpackage

[rtl/core/pfe_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pfe_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pfe_pkg::DATA_W-1:0]  i_dividend,
    input  logic [pfe_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pfe_pkg::DATA_W-1:0]  o_quotient
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg;

    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_mag_a;
    logic [DATA_W-1:0] w_mag_b;

    assign w_mag_a = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_mag_b = i_divisor[DATA_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;
    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // remainder always stays below the divisor, so it fits in DATA_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag_a;
            r_dvs <= w_mag_b;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

[rtl/core/pfe_dp.sv]
// Datapath: operand stack memory, cached top word, ALU, divider and result register.
module pfe_dp #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pfe_pkg::SYM_W-1:0]     i_symbol,
    input  pfe_pkg::t_cmd                 i_cmd,
    output pfe_pkg::t_stat                o_stat,
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output logic [pfe_pkg::DATA_W-1:0]    o_value,
    output logic [pfe_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_push_dropped
);
    import pfe_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0] r_tos;
    logic [CW-1:0]     r_count;
    t_status           r_err;
    logic              r_ovf;
    t_op               r_op;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_value;
    t_status           r_status;
    logic              r_dropped;

    logic [CW-1:0]     w_cnt_m1;
    logic [CW-1:0]     w_cnt_m2;
    logic              w_full;
    logic              w_empty;
    logic [3:0]        w_digit;
    logic [DATA_W-1:0] w_alu;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quot;
    logic              w_wr_en;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_full   = (r_count == CW'(STACK_DEPTH));
    assign w_empty  = (r_count == '0);
    // digit codes sit at 0x30..0x39, so the low nibble is the value
    assign w_digit  = i_symbol[3:0];
    assign w_wr_en  = i_cmd.push_digit && !w_full && !w_empty;

    always_comb begin
        case (r_op)
            OP_ADD:  w_alu = r_rd + r_tos;
            OP_SUB:  w_alu = r_rd - r_tos;
            OP_MUL:  w_alu = r_rd * r_tos;
            default: w_alu = r_rd;
        endcase
    end

    pfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd),
        .i_divisor  (r_tos),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // entries below the top word; the top lives in r_tos
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_cnt_m1[AW-1:0]] <= r_tos;
        end
        r_rd <= r_mem[w_cnt_m2[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_err       <= ST_OK;
                r_ovf       <= 1'b0;
            end else if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.push_digit) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.set_err) begin
                r_err <= i_cmd.err_code;
            end
            if (i_cmd.pop_two) begin
                r_count <= w_cnt_m2;
            end
            if (i_cmd.commit_alu || i_cmd.div_commit) begin
                r_count <= w_cnt_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_digit && !w_full) begin
            r_tos <= {{(DATA_W-4){1'b0}}, w_digit};
        end else if (i_cmd.commit_alu) begin
            r_tos <= w_alu;
        end else if (i_cmd.div_commit) begin
            r_tos <= w_quot;
        end
        if (i_cmd.latch_op) begin
            r_op <= decode_op(i_symbol);
        end
        if (i_cmd.finish) begin
            r_dropped <= r_ovf;
            if (r_err != ST_OK) begin
                r_status <= r_err;
                r_value  <= '0;
            end else if (w_empty) begin
                r_status <= ST_UNDERFLOW;
                r_value  <= '0;
            end else begin
                r_status <= ST_OK;
                r_value  <= r_tos;
            end
        end
    end

    assign o_stat.sym_nul     = (i_symbol == CH_NUL);
    assign o_stat.sym_digit   = (i_symbol >= CH_ZERO) && (i_symbol <= CH_NINE);
    assign o_stat.err_latched = (r_err != ST_OK);
    assign o_stat.count_lt2   = (r_count < CW'(2));
    assign o_stat.rhs_zero    = (r_tos == '0);
    assign o_stat.out_busy    = r_out_valid && !i_res_ready;
    assign o_stat.div_done    = w_div_done;
    assign o_stat.op          = r_op;

    assign o_res_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_status       = r_status;
    assign o_push_dropped = r_dropped;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_count == '0) && (r_err == ST_OK) && !r_ovf && r_out_valid)
        else $error("end of expression did not clear state and raise result");

endmodule

[rtl/core/pfe_ctrl.sv]
// Controller: sequences symbol handling, operator execution and division.
module pfe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_sym_valid,
    output logic            o_sym_ready,
    input  pfe_pkg::t_stat  i_stat,
    output pfe_pkg::t_cmd   o_cmd
);
    import pfe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_take;

    assign o_sym_ready = (r_state == S_IDLE) && !(i_stat.sym_nul && i_stat.out_busy);
    assign w_take      = i_sym_valid && o_sym_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.err_code = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_stat.sym_nul) begin
                        o_cmd.finish = 1'b1;
                    end else if (i_stat.err_latched) begin
                        o_cmd.finish = 1'b0;
                    end else if (i_stat.sym_digit) begin
                        o_cmd.push_digit = 1'b1;
                    end else if (i_stat.count_lt2) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_UNDERFLOW;
                    end else begin
                        o_cmd.latch_op = 1'b1;
                        n_state        = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (i_stat.op)
                    OP_ADD, OP_SUB, OP_MUL: begin
                        o_cmd.commit_alu = 1'b1;
                    end
                    OP_DIV: begin
                        if (i_stat.rhs_zero) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_DIVZERO;
                            o_cmd.pop_two  = 1'b1;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    default: begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_INVALID;
                        o_cmd.pop_two  = 1'b1;
                    end
                endcase
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_div_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_stat.div_done) |=> (r_state == S_IDLE))
        else $error("divider finished but controller did not return");

    a_nul_not_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_stat.sym_nul) |-> !i_stat.out_busy)
        else $error("end of expression taken over an unread result");

endmodule

[rtl/core/postfix_expression_evaluator_top.sv]
// Top level of the postfix expression evaluator.
//
// Input channel: i_sym_valid / o_sym_ready carry one ASCII symbol word per
// handshake on i_symbol. Digits push, + - * / operate, NUL ends the expression.
// Output channel: o_res_valid / i_res_ready carry one result word per
// expression: o_value, o_status (ok, underflow, divide by zero, invalid) and
// o_push_dropped.
// Per symbol: a digit or an ignored symbol is handled in S_IDLE, + - * pass
// through S_EXEC, and / through S_EXEC and then S_DIV while the bit-serial
// divider runs. A NUL's result is on the output the cycle after it is taken.
// The result sits in an output register; symbols keep flowing while it waits,
// and only a following NUL is held off until the pending result is taken.
// Reset clears the stack count, the latched error, the overflow flag and the
// output valid; stack entries themselves are not cleared and are only read
// after being written.
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sym_valid,
    output logic                          o_sym_ready,
    input  logic [pfe_pkg::SYM_W-1:0]     i_symbol,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic signed [pfe_pkg::DATA_W-1:0] o_value,
    output logic [pfe_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_push_dropped
);
    import pfe_pkg::*;

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [DATA_W-1:0] w_value;

    pfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym_valid (i_sym_valid),
        .o_sym_ready (o_sym_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pfe_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_symbol       (i_symbol),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_res_ready    (i_res_ready),
        .o_res_valid    (o_res_valid),
        .o_value        (w_value),
        .o_status       (o_status),
        .o_push_dropped (o_push_dropped)
    );

    assign o_value = signed'(w_value);

endmodule
